[rtl/bop_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bop_pkg
// Types, constants and pipeline stage map of the Black forward-formula pricer.
// ----------------------------------------------------------------------------
package bop_pkg;

    localparam int FRAC_BITS = 16;

    localparam int EPS_W   = 17;
    localparam int KIND_W  = 3;
    localparam int PX_W    = 32;
    localparam int TIME_W  = 31;
    localparam int DF_W    = 17;
    localparam int VOL_W   = 31;

    localparam logic [EPS_W-1:0] EPS_RESET = 17'd1;

    localparam logic [30:0] ONE_Q30  = 31'd1073741824;
    localparam logic [29:0] LN2_Q30  = 30'd744261118;
    localparam int          DQ       = 24;
    localparam logic signed [31:0] DLIM   = 32'sd268435456;
    localparam logic signed [31:0] DLIM_N = -32'sd268435456;
    localparam logic [24:0] CDF_C1   = 25'd26803280;
    localparam logic [20:0] CDF_C3   = 21'd1183901;
    localparam int          LOGF     = 28;

    typedef enum logic [2:0] {
        KIND_CALL     = 3'd0,
        KIND_PUT      = 3'd1,
        KIND_STRADDLE = 3'd2,
        KIND_DCALL    = 3'd3,
        KIND_DPUT     = 3'd4
    } kind_t;

    // stage map
    localparam int ST_MAG    = 1;
    localparam int ST_NORM0  = 2;
    localparam int N_NORM    = 5;
    localparam int ST_LOGI   = ST_NORM0 + N_NORM;
    localparam int ST_SQ0    = ST_LOGI + 1;
    localparam int ST_LDIFF  = ST_SQ0 + LOGF;
    localparam int ST_SQRT0  = 2;
    localparam int N_SQRT    = 24;
    localparam int ST_SD     = ST_SQRT0 + N_SQRT;
    localparam int ST_FLAGS  = ST_SD + 1;
    localparam int ST_LNP    = ST_LDIFF + 1;
    localparam int ST_LNQ    = ST_LNP + 1;
    localparam int ST_DINIT  = ST_LNQ + 1;
    localparam int ST_DIV0   = ST_DINIT + 1;
    localparam int N_DIV     = 29;
    localparam int ST_LND    = ST_DIV0 + N_DIV;
    localparam int ST_DRAW   = ST_LND + 1;
    localparam int ST_DSEL   = ST_DRAW + 1;
    localparam int ST_C1     = ST_DSEL + 1;
    localparam int ST_C2     = ST_C1 + 1;
    localparam int ST_C3     = ST_C2 + 1;
    localparam int ST_C4     = ST_C3 + 1;
    localparam int ST_C5     = ST_C4 + 1;
    localparam int ST_C6     = ST_C5 + 1;
    localparam int ST_HOR0   = ST_C6 + 1;
    localparam int N_HOR     = 24;
    localparam int ST_EXP    = ST_HOR0 + N_HOR;
    localparam int ST_PDIV0  = ST_EXP + 1;
    localparam int N_PDIV    = 31;
    localparam int ST_NSEL   = ST_PDIV0 + N_PDIV;
    localparam int ST_COEF   = ST_NSEL + 1;
    localparam int ST_MUL    = ST_COEF + 1;
    localparam int ST_INNER  = ST_MUL + 1;
    localparam int ST_DFM    = ST_INNER + 1;
    localparam int ST_RND    = ST_DFM + 1;
    localparam int ST_SAT    = ST_RND + 1;
    localparam int LAST_ST   = ST_SAT;

    typedef struct packed {
        logic [2:0]         kind;
        logic signed [31:0] f;
        logic signed [31:0] k;
        logic [16:0]        df;
        logic [30:0]        vol;
        logic [30:0]        t;
        logic [1:0][31:0]   mag;
        logic [1:0][31:0]   nm;
        logic [1:0][4:0]    sh;
        logic [1:0][30:0]   lz;
        logic [1:0][4:0]    le;
        logic [1:0][27:0]   lf;
        logic [47:0]        srem;
        logic [23:0]        sroot;
        logic [38:0]        sd;
        logic               deg;
        logic               fge;
        logic               fzero;
        logic               big;
        logic               lneg;
        logic [33:0]        lmag;
        logic [46:0]        plo;
        logic [46:0]        phi;
        logic [44:0]        num;
        logic [23:0]        drem;
        logic [28:0]        dq;
        logic               dovf;
        logic signed [31:0] lnd;
        logic [1:0][31:0]   d;
        logic [1:0]         cneg;
        logic [1:0][28:0]   ca;
        logic [1:0][32:0]   ca2;
        logic [1:0][36:0]   ca3;
        logic [1:0][29:0]   ct1;
        logic [1:0][39:0]   cu30;
        logic [1:0][4:0]    cn;
        logic [1:0]         cez;
        logic [1:0][29:0]   cr;
        logic [1:0][30:0]   cacc;
        logic [1:0][29:0]   cx;
        logic [1:0][29:0]   cq;
        logic [1:0][31:0]   cden;
        logic [1:0][31:0]   prem;
        logic [1:0][30:0]   pq;
        logic [1:0][30:0]   nv;
        logic signed [31:0] coa;
        logic signed [31:0] cob;
        logic [30:0]        dsel;
        logic signed [63:0] fa;
        logic signed [63:0] kb;
        logic [47:0]        dn;
        logic signed [43:0] iq;
        logic signed [61:0] pr;
        logic [17:0]        pdig;
        logic signed [35:0] price;
        logic [31:0]        pout;
        logic               sat;
    } slot_t;

    function automatic logic [34:0] nln2(input logic [4:0] n);
        return 35'(n) * 35'(LN2_Q30);
    endfunction

    function automatic logic signed [31:0] clampd(input logic signed [31:0] d);
        logic signed [31:0] r;
        r = d;
        if (d > DLIM) begin
            r = DLIM;
        end else if (d < DLIM_N) begin
            r = DLIM_N;
        end
        return r;
    endfunction

endpackage

[rtl/black_option_pricer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// black_option_pricer
// Pipelined Black-76 pricer: call, put, straddle, digital call and put.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel s_*: one option request per valid/ready handshake.
//   Result channel m_*: price (signed Q16.16, saturated) and a clip flag.
//   Config channel cfg_*: writes eps_threshold; always ready. Write it only
//   while no request is in flight.
//   Throughput: one request per cycle while s_ready is high. The pipeline
//   is built from bit-serial stages (24-step square root, 28-step log2
//   squaring, 29-step quotient, 31-step reciprocal, one register stage
//   per step) and the 8-term exp series at three register stages per
//   term.
//   Reset: synchronous, active low; empties the pipeline and sets
//   eps_threshold to 1.
//   Receiver stall: the result holds on m_*; one more result is parked in a
//   skid register, then s_ready drops and the whole pipeline freezes.
// ----------------------------------------------------------------------------
module black_option_pricer (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [bop_pkg::EPS_W-1:0]     cfg_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [bop_pkg::KIND_W-1:0]    s_kind,
    input  logic signed [bop_pkg::PX_W-1:0] s_forward,
    input  logic signed [bop_pkg::PX_W-1:0] s_strike,
    input  logic [bop_pkg::TIME_W-1:0]    s_expiry,
    input  logic [bop_pkg::DF_W-1:0]      s_discount,
    input  logic [bop_pkg::VOL_W-1:0]     s_volatility,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [bop_pkg::PX_W-1:0] m_price,
    output logic                          m_saturated
);
    import bop_pkg::*;

    logic [EPS_W-1:0] eps_reg;
    logic [LAST_ST:0] vld_reg;
    slot_t            st_reg  [0:LAST_ST];
    slot_t            st_next [1:LAST_ST];
    slot_t            in_slot;
    logic             pipe_ce;

    logic             m_valid_reg;
    logic [31:0]      m_price_reg;
    logic             m_sat_reg;
    logic             skid_vld_reg;
    logic [31:0]      skid_price_reg;
    logic             skid_sat_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            eps_reg <= EPS_RESET;
        end else if (cfg_valid) begin
            eps_reg <= cfg_data;
        end
    end

    assign pipe_ce = !skid_vld_reg;
    assign s_ready = pipe_ce;

    always_comb begin
        in_slot       = '0;
        in_slot.kind  = s_kind;
        in_slot.f     = s_forward;
        in_slot.k     = s_strike;
        in_slot.df    = s_discount;
        in_slot.vol   = s_volatility;
        in_slot.t     = s_expiry;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (pipe_ce) begin
            vld_reg <= {vld_reg[LAST_ST-1:0], s_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_ce) begin
            st_reg[0] <= in_slot;
            for (int i = 1; i <= LAST_ST; i++) begin
                st_reg[i] <= st_next[i];
            end
        end
    end

    for (genvar g = 1; g <= LAST_ST; g++) begin : g_stage
        localparam bit IN_NORM = (g >= ST_NORM0) && (g < ST_NORM0 + N_NORM);
        localparam int NW      = IN_NORM ? (16 >> (g - ST_NORM0)) : 1;
        localparam bit IN_SQ   = (g >= ST_SQ0) && (g < ST_LDIFF);
        localparam bit IN_SQRT = (g >= ST_SQRT0) && (g < ST_SD);
        localparam int SI      = IN_SQRT ? (N_SQRT - 1 - (g - ST_SQRT0)) : 0;
        localparam bit IN_DIV  = (g >= ST_DIV0) && (g < ST_LND);
        localparam int DI      = IN_DIV ? (N_DIV - 1 - (g - ST_DIV0)) : 0;
        localparam bit IN_HOR  = (g >= ST_HOR0) && (g < ST_EXP);
        localparam int HS      = IN_HOR ? ((g - ST_HOR0) % 3) : 0;
        localparam int HK      = IN_HOR ? (8 - (g - ST_HOR0) / 3) : 1;
        localparam logic [32:0] HM = 33'((64'd1 << 32) / HK);
        localparam bit IN_PDIV = (g >= ST_PDIV0) && (g < ST_NSEL);
        localparam int PI      = IN_PDIV ? (N_PDIV - 1 - (g - ST_PDIV0)) : 0;

        always_comb begin
            slot_t              nx;
            logic [47:0]        trial;
            logic [61:0]        zz;
            logic [31:0]        sqv;
            logic [32:0]        vf;
            logic [32:0]        vk;
            logic [33:0]        dl;
            logic [63:0]        lsum;
            logic [32:0]        lnq;
            logic [23:0]        dt;
            logic [28:0]        qc;
            logic [31:0]        sdq;
            logic signed [31:0] d0;
            logic signed [31:0] d1;
            logic signed [31:0] dv;
            logic [33:0]        u;
            logic [4:0]         cnt;
            logic [29:0]        rm;
            logic [29:0]        qq;
            logic [30:0]        ev;
            logic [31:0]        pt;
            logic signed [31:0] n1;
            logic signed [31:0] n2;
            logic signed [63:0] inner;
            logic signed [61:0] prr;
            logic signed [35:0] pv;

            nx    = st_reg[g-1];
            trial = '0;
            zz    = '0;
            sqv   = '0;
            vf    = '0;
            vk    = '0;
            dl    = '0;
            lsum  = '0;
            lnq   = '0;
            dt    = '0;
            qc    = '0;
            sdq   = '0;
            d0    = '0;
            d1    = '0;
            dv    = '0;
            u     = '0;
            cnt   = '0;
            rm    = '0;
            qq    = '0;
            ev    = '0;
            pt    = '0;
            n1    = '0;
            n2    = '0;
            inner = '0;
            prr   = '0;
            pv    = '0;

            // magnitudes and square root seed
            if (g == ST_MAG) begin
                nx.mag[0] = nx.f[31] ? (32'd0 - nx.f) : nx.f;
                nx.mag[1] = nx.k[31] ? (32'd0 - nx.k) : nx.k;
                nx.nm[0]  = nx.mag[0];
                nx.nm[1]  = nx.mag[1];
                nx.sh     = '0;
                nx.srem   = 48'(nx.t) << FRAC_BITS;
                nx.sroot  = '0;
            end

            // leading-one normalize
            if (IN_NORM) begin
                for (int l = 0; l < 2; l++) begin
                    if (nx.nm[l][31 -: NW] == '0) begin
                        nx.nm[l] = nx.nm[l] << NW;
                        nx.sh[l] = nx.sh[l] + 5'(NW);
                    end
                end
            end

            if (g == ST_LOGI) begin
                for (int l = 0; l < 2; l++) begin
                    nx.lz[l] = nx.nm[l][31:1];
                    nx.le[l] = 5'd31 - nx.sh[l];
                    nx.lf[l] = '0;
                end
            end

            // log2 fraction, one bit per squaring
            if (IN_SQ) begin
                for (int l = 0; l < 2; l++) begin
                    zz       = 62'(nx.lz[l]) * 62'(nx.lz[l]);
                    sqv      = zz[61:30];
                    nx.lz[l] = sqv[31] ? sqv[31:1] : sqv[30:0];
                    nx.lf[l] = {nx.lf[l][26:0], sqv[31]};
                end
            end

            // integer square root, one result bit per stage
            if (IN_SQRT) begin
                trial = (48'(nx.sroot) << (SI + 1)) + (48'd1 << (2 * SI));
                if (nx.srem >= trial) begin
                    nx.srem      = nx.srem - trial;
                    nx.sroot[SI] = 1'b1;
                end
            end

            if (g == ST_SD) begin
                nx.sd = 39'((62'(nx.vol) * 62'(nx.sroot)) >> FRAC_BITS);
            end

            if (g == ST_FLAGS) begin
                nx.deg   = (nx.sd < 39'(eps_reg)) || (nx.sd == '0) ||
                           (nx.mag[1] < 32'(eps_reg)) || (nx.k == '0) ||
                           ((nx.f != '0) && (nx.f[31] != nx.k[31]));
                nx.fge   = !($signed(nx.f) < $signed(nx.k));
                nx.fzero = (nx.f == '0);
                nx.big   = nx.sd > (39'd64 << FRAC_BITS);
            end

            if (g == ST_LDIFF) begin
                vf      = {nx.le[0], nx.lf[0]};
                vk      = {nx.le[1], nx.lf[1]};
                dl      = {1'b0, vf} - {1'b0, vk};
                nx.lneg = dl[33];
                nx.lmag = dl[33] ? (34'd0 - dl) : dl;
            end

            if (g == ST_LNP) begin
                nx.plo = 47'(nx.lmag[16:0]) * 47'(LN2_Q30);
                nx.phi = 47'(nx.lmag[33:17]) * 47'(LN2_Q30);
            end

            if (g == ST_LNQ) begin
                lsum   = (64'(nx.phi) << 17) + 64'(nx.plo);
                lnq    = lsum[62:30];
                nx.num = 45'(lnq) << (FRAC_BITS - 4);
            end

            if (g == ST_DINIT) begin
                nx.drem = 24'(nx.num[44:29]);
                nx.dovf = 23'(nx.num[44:29]) >= nx.sd[22:0];
                nx.dq   = '0;
            end

            // quotient of ln term by std, one bit per stage
            if (IN_DIV) begin
                dt = {nx.drem[22:0], nx.num[DI]};
                if (dt >= {1'b0, nx.sd[22:0]}) begin
                    nx.drem   = dt - {1'b0, nx.sd[22:0]};
                    nx.dq[DI] = 1'b1;
                end else begin
                    nx.drem = dt;
                end
            end

            if (g == ST_LND) begin
                qc     = (nx.dovf || (nx.dq > 29'(DLIM))) ? 29'(DLIM) : nx.dq;
                nx.lnd = nx.lneg ? (32'sd0 - $signed(32'(qc))) : $signed(32'(qc));
            end

            if (g == ST_DRAW) begin
                sdq     = 32'(nx.sd[22:0]) << (DQ - FRAC_BITS);
                d0      = nx.lnd + $signed(sdq >> 1);
                d1      = d0 - $signed(sdq);
                nx.d[0] = d0;
                nx.d[1] = d1;
            end

            if (g == ST_DSEL) begin
                if (nx.deg) begin
                    nx.d[0] = nx.fge ? DLIM : DLIM_N;
                    nx.d[1] = nx.fge ? DLIM : DLIM_N;
                end else if (nx.fzero) begin
                    nx.d[0] = DLIM_N;
                    nx.d[1] = DLIM_N;
                end else if (nx.big) begin
                    nx.d[0] = DLIM;
                    nx.d[1] = DLIM_N;
                end else begin
                    nx.d[0] = clampd($signed(nx.d[0]));
                    nx.d[1] = clampd($signed(nx.d[1]));
                end
            end

            // normal CDF lanes: d1 in lane 0, d2 in lane 1
            if (g == ST_C1) begin
                for (int l = 0; l < 2; l++) begin
                    dv         = $signed(nx.d[l]);
                    nx.cneg[l] = dv[31];
                    dv         = dv[31] ? (32'sd0 - dv) : dv;
                    nx.ca[l]   = dv[28:0];
                end
            end

            if (g == ST_C2) begin
                for (int l = 0; l < 2; l++) begin
                    nx.ca2[l] = 33'((58'(nx.ca[l]) * 58'(nx.ca[l])) >> DQ);
                    nx.ct1[l] = 30'((54'(nx.ca[l]) * 54'(CDF_C1)) >> DQ);
                end
            end

            if (g == ST_C3) begin
                for (int l = 0; l < 2; l++) begin
                    nx.ca3[l] = 37'((62'(nx.ca2[l]) * 62'(nx.ca[l])) >> DQ);
                end
            end

            if (g == ST_C4) begin
                for (int l = 0; l < 2; l++) begin
                    u          = 34'(nx.ct1[l]) +
                                 34'((58'(nx.ca3[l]) * 58'(CDF_C3)) >> DQ);
                    nx.cu30[l] = 40'(u) << 6;
                end
            end

            // u = n*ln2 + r: thermometer of ln2 multiples
            if (g == ST_C5) begin
                for (int l = 0; l < 2; l++) begin
                    cnt = '0;
                    for (int j = 1; j <= 30; j++) begin
                        if (nx.cu30[l] >= 40'(nln2(5'(j)))) begin
                            cnt = cnt + 5'd1;
                        end
                    end
                    nx.cn[l]  = cnt;
                    nx.cez[l] = nx.cu30[l] >= (40'd31 * 40'(LN2_Q30));
                end
            end

            if (g == ST_C6) begin
                for (int l = 0; l < 2; l++) begin
                    nx.cr[l]   = 30'(nx.cu30[l] - 40'(nln2(nx.cn[l])));
                    nx.cacc[l] = ONE_Q30;
                end
            end

            // exp(-r) Horner series, three stages per term
            if (IN_HOR) begin
                for (int l = 0; l < 2; l++) begin
                    case (HS)
                        0: begin
                            nx.cx[l] = 30'((61'(nx.cr[l]) * 61'(nx.cacc[l])) >> 30);
                        end
                        1: begin
                            nx.cq[l] = 30'((63'(nx.cx[l]) * 63'(HM)) >> 32);
                        end
                        default: begin
                            rm         = nx.cx[l] - 30'(33'(nx.cq[l]) * 33'(HK));
                            qq         = (rm >= 30'(HK)) ? (nx.cq[l] + 30'd1) : nx.cq[l];
                            nx.cacc[l] = ONE_Q30 - 31'(qq);
                        end
                    endcase
                end
            end

            if (g == ST_EXP) begin
                for (int l = 0; l < 2; l++) begin
                    ev         = nx.cez[l] ? 31'd0 : (nx.cacc[l] >> nx.cn[l]);
                    nx.cden[l] = 32'(ONE_Q30) + 32'(ev);
                    nx.prem[l] = 32'd1 << 29;
                    nx.pq[l]   = '0;
                end
            end

            // 2^60 / (2^30 + e), one quotient bit per stage
            if (IN_PDIV) begin
                for (int l = 0; l < 2; l++) begin
                    pt = nx.prem[l] << 1;
                    if (pt >= nx.cden[l]) begin
                        nx.prem[l]   = pt - nx.cden[l];
                        nx.pq[l][PI] = 1'b1;
                    end else begin
                        nx.prem[l] = pt;
                    end
                end
            end

            if (g == ST_NSEL) begin
                for (int l = 0; l < 2; l++) begin
                    nx.nv[l] = nx.cneg[l] ? (ONE_Q30 - nx.pq[l]) : nx.pq[l];
                end
            end

            if (g == ST_COEF) begin
                n1 = $signed({1'b0, nx.nv[0]});
                n2 = $signed({1'b0, nx.nv[1]});
                nx.dsel = (nx.kind == KIND_DPUT) ? (ONE_Q30 - nx.nv[1]) : nx.nv[1];
                case (nx.kind)
                    KIND_CALL: begin
                        nx.coa = n1;
                        nx.cob = n2;
                    end
                    KIND_PUT: begin
                        nx.coa = n1 - $signed({1'b0, ONE_Q30});
                        nx.cob = n2 - $signed({1'b0, ONE_Q30});
                    end
                    KIND_STRADDLE: begin
                        nx.coa = (n1 <<< 1) - $signed({1'b0, ONE_Q30});
                        nx.cob = (n2 <<< 1) - $signed({1'b0, ONE_Q30});
                    end
                    default: begin
                        nx.coa = '0;
                        nx.cob = '0;
                    end
                endcase
            end

            if (g == ST_MUL) begin
                nx.fa = 64'(nx.f) * 64'(nx.coa);
                nx.kb = 64'(nx.k) * 64'(nx.cob);
                nx.dn = 48'(nx.df) * 48'(nx.dsel);
            end

            if (g == ST_INNER) begin
                inner = nx.fa - nx.kb + 64'sd524288;
                nx.iq = 44'(inner >>> 20);
            end

            if (g == ST_DFM) begin
                prr     = 62'(nx.iq) * $signed({45'd0, nx.df});
                nx.pr   = prr;
                nx.pdig = 18'((nx.dn + (48'd1 << 29)) >> 30);
            end

            if (g == ST_RND) begin
                pv = 36'((nx.pr + (62'sd1 <<< (FRAC_BITS + 9))) >>> (FRAC_BITS + 10));
                case (nx.kind)
                    KIND_CALL, KIND_PUT, KIND_STRADDLE: nx.price = pv;
                    KIND_DCALL, KIND_DPUT:              nx.price = $signed(36'(nx.pdig));
                    default:                            nx.price = '0;
                endcase
            end

            if (g == ST_SAT) begin
                if (nx.price > 36'sd2147483647) begin
                    nx.pout = 32'h7FFF_FFFF;
                    nx.sat  = 1'b1;
                end else if (nx.price < -36'sd2147483648) begin
                    nx.pout = 32'h8000_0000;
                    nx.sat  = 1'b1;
                end else begin
                    nx.pout = nx.price[31:0];
                    nx.sat  = 1'b0;
                end
            end

            st_next[g] = nx;
        end
    end

    // output register with one-deep skid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end else if (!m_valid_reg || m_ready) begin
            if (skid_vld_reg) begin
                m_valid_reg  <= 1'b1;
                skid_vld_reg <= 1'b0;
            end else begin
                m_valid_reg <= vld_reg[LAST_ST];
            end
        end else if (vld_reg[LAST_ST] && pipe_ce) begin
            skid_vld_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!m_valid_reg || m_ready) begin
            if (skid_vld_reg) begin
                m_price_reg <= skid_price_reg;
                m_sat_reg   <= skid_sat_reg;
            end else begin
                m_price_reg <= st_reg[LAST_ST].pout;
                m_sat_reg   <= st_reg[LAST_ST].sat;
            end
        end else if (vld_reg[LAST_ST] && pipe_ce) begin
            skid_price_reg <= st_reg[LAST_ST].pout;
            skid_sat_reg   <= st_reg[LAST_ST].sat;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_price     = m_price_reg;
    assign m_saturated = m_sat_reg;

endmodule
